// ===== rtl/core/imtf_pkg.sv =====
// ----------------------------------------------------------------------------
// imtf_pkg: shared definitions of the interleaved move-to-front unit
// Sizes, the lane vector type, engine state codes and the structs that pass
// between the row walker, the row update logic and the top level.
// ----------------------------------------------------------------------------
package imtf_pkg;

   localparam int LANES      = 16;
   localparam int SYMBOLS    = 256;
   localparam int SYM_W      = 8;
   localparam int LCNT_W     = 5;
   localparam int ROW_W      = $clog2(SYMBOLS);
   localparam int ROW_CNT_W  = $clog2(SYMBOLS + 1);
   localparam int ROW_DATA_W = LANES * SYM_W;

   localparam logic [SYM_W-1:0] NOT_FOUND = 8'hFF;

   typedef logic [LANES-1:0][SYM_W-1:0] lane_vec_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } eng_state_type;

   typedef struct packed {
      logic [LANES-1:0]      hit;
      lane_vec_type          wdata;
   } row_upd_type;

   typedef struct packed {
      lane_vec_type          ranks;
      logic                  all_same;
   } result_type;

endpackage

// ===== rtl/core/imtf_ram.sv =====
// ----------------------------------------------------------------------------
// imtf_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module imtf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/imtf_row_update.sv =====
// ----------------------------------------------------------------------------
// imtf_row_update: per-lane compare and shift logic for one list row
// Flags the lanes whose symbol sits in this row and forms the row as it is
// written back: lanes still searching take the entry of the row above, or
// their own symbol at the front row; lanes already found keep the row.
// ----------------------------------------------------------------------------
module imtf_row_update import imtf_pkg::*; (
   input  lane_vec_type       row_data,
   input  lane_vec_type       prev_data,
   input  lane_vec_type       symbols,
   input  logic [LANES-1:0]   found,
   input  logic [ROW_W-1:0]   row,
   output row_upd_type        upd
);

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         upd.hit[l] = !found[l] && (row_data[l] == symbols[l]);
         if (found[l]) begin
            upd.wdata[l] = row_data[l];
         end else if (row == '0) begin
            upd.wdata[l] = symbols[l];
         end else begin
            upd.wdata[l] = prev_data[l];
         end
      end
   end

endmodule

// ===== rtl/core/imtf_engine.sv =====
// ----------------------------------------------------------------------------
// imtf_engine: row walker of the interleaved move-to-front unit
// Reads the list memory one row per cycle, records each lane's rank when
// its symbol turns up and, on a full block, writes every row back shifted
// until all lanes have found their symbol. Rows never written read as the
// identity list through one valid bit per row.
// ----------------------------------------------------------------------------
module imtf_engine import imtf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  lane_vec_type       symbols,
   input  logic [LCNT_W-1:0]  lane_count,
   output logic               busy,
   output logic               res_valid,
   input  logic               res_ready,
   output result_type         res
);

   eng_state_type           state_ff, state_in;
   lane_vec_type            sym_ff, sym_in;
   lane_vec_type            rank_ff, rank_in;
   lane_vec_type            prev_ff, prev_in;
   logic [LANES-1:0]        found_ff, found_in;
   logic                    full_ff, full_in;
   logic [ROW_CNT_W-1:0]    issue_ff, issue_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [ROW_W-1:0]        chk_row_ff, chk_row_in;
   logic [SYMBOLS-1:0]      row_vld_ff;

   logic [LANES-1:0]        lane_act;
   logic [LANES-1:0]        sym_abs;
   logic [LANES-1:0]        init_found;
   lane_vec_type            init_row;
   lane_vec_type            row_data;
   logic [ROW_DATA_W-1:0]   ram_rdata;
   logic                    rd_en;
   logic                    wr_en;
   row_upd_type             upd;
   logic                    same;

   imtf_ram #(
      .WIDTH (ROW_DATA_W),
      .DEPTH (SYMBOLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (chk_row_ff),
      .wr_data (upd.wdata),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ROW_W-1:0]),
      .rd_data (ram_rdata)
   );

   imtf_row_update u_upd (
      .row_data  (row_data),
      .prev_data (prev_ff),
      .symbols   (sym_ff),
      .found     (found_ff),
      .row       (chk_row_ff),
      .upd       (upd)
   );

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_act[l]   = LCNT_W'(l) < lane_count;
         sym_abs[l]    = 32'(symbols[l]) >= SYMBOLS;
         init_found[l] = !lane_act[l] || sym_abs[l];
         init_row[l]   = SYM_W'(chk_row_ff);
      end
   end

   assign row_data = row_vld_ff[chk_row_ff] ? lane_vec_type'(ram_rdata) : init_row;

   always_comb begin
      same = full_ff;
      for (int l = 1; l < LANES; l++) begin
         if (rank_ff[l] != rank_ff[0]) begin
            same = 1'b0;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      sym_in     = sym_ff;
      rank_in    = rank_ff;
      prev_in    = prev_ff;
      found_in   = found_ff;
      full_in    = full_ff;
      issue_in   = issue_ff;
      chk_vld_in = 1'b0;
      chk_row_in = chk_row_ff;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      res_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sym_in   = symbols;
               full_in  = lane_count >= LCNT_W'(LANES);
               found_in = init_found;
               issue_in = '0;
               for (int l = 0; l < LANES; l++) begin
                  rank_in[l] = (lane_act[l] && sym_abs[l]) ? NOT_FOUND : '0;
               end
               state_in = (&init_found) ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue_ff < ROW_CNT_W'(SYMBOLS)) begin
               rd_en      = 1'b1;
               issue_in   = issue_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_row_in = issue_ff[ROW_W-1:0];
            end
            if (chk_vld_ff) begin
               wr_en    = full_ff;
               found_in = found_ff | upd.hit;
               prev_in  = row_data;
               for (int l = 0; l < LANES; l++) begin
                  if (upd.hit[l]) begin
                     rank_in[l] = SYM_W'(chk_row_ff);
                  end
               end
               if ((&found_in) || (chk_row_ff == ROW_W'(SYMBOLS - 1))) begin
                  chk_vld_in = 1'b0;
                  state_in   = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (wr_en) begin
         row_vld_ff[chk_row_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff     <= sym_in;
      rank_ff    <= rank_in;
      prev_ff    <= prev_in;
      found_ff   <= found_in;
      full_ff    <= full_in;
      issue_ff   <= issue_in;
      chk_row_ff <= chk_row_in;
   end

   assign busy         = state_ff != ST_IDLE;
   assign res.ranks    = rank_ff;
   assign res.all_same = same;

endmodule

// ===== rtl/core/interleaved_move_to_front_16lane_unit.sv =====
// ----------------------------------------------------------------------------
// interleaved_move_to_front_16lane_unit: sixteen-lane move-to-front ranker
// Top level with the request side, the row walker and the result register.
// ----------------------------------------------------------------------------
// Each request transfer carries up to sixteen bytes, one per lane, and each
// lane keeps its own 256-entry move-to-front list. All sixteen lists share
// one memory row per list position, so the block reads one row per cycle
// and stops as soon as every active lane has found its byte. A block's result
// is ready once the row of its largest rank has been checked, a block with no
// active lane goes straight to the result, and the next request is taken in
// the cycle after the result is handed to the output register. A full block
// (lane count 16 or more) also moves every byte to the front of its list as
// the rows are walked; a tail block only reports ranks. The lists come out
// of reset as the identity order at once, with no clearing pass.
// ----------------------------------------------------------------------------
module interleaved_move_to_front_16lane_unit import imtf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [63:0]   req_symbols_low,
   input  logic [63:0]   req_symbols_high,
   input  logic [4:0]    req_lane_count,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [63:0]   rsp_ranks_low,
   output logic [63:0]   rsp_ranks_high,
   output logic          rsp_all_same
);

   logic          busy;
   logic          start;
   logic          res_valid;
   logic          res_ready;
   result_type    res;

   logic          rsp_valid_ff;
   logic [63:0]   rsp_ranks_low_ff;
   logic [63:0]   rsp_ranks_high_ff;
   logic          rsp_all_same_ff;

   assign req_stall = busy;
   assign start     = req_valid && !busy;
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   imtf_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .symbols    (lane_vec_type'({req_symbols_high, req_symbols_low})),
      .lane_count (req_lane_count),
      .busy       (busy),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ranks_low_ff  <= res.ranks[LANES/2-1:0];
         rsp_ranks_high_ff <= res.ranks[LANES-1:LANES/2];
         rsp_all_same_ff   <= res.all_same;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ranks_low  = rsp_ranks_low_ff;
   assign rsp_ranks_high = rsp_ranks_high_ff;
   assign rsp_all_same   = rsp_all_same_ff;

endmodule

// ===== rtl/core/imtf_checker.sv =====
// ----------------------------------------------------------------------------
// imtf_checker: port-level checks of the move-to-front unit
// Watches the ports for stalled results that change, result transfers
// without a request, too many items in flight and wrong all-same flags.
// ----------------------------------------------------------------------------
module imtf_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  logic [63:0]   rsp_ranks_low,
   input  logic [63:0]   rsp_ranks_high,
   input  logic          rsp_all_same
);

   logic          req_xfer;
   logic          rsp_xfer;
   logic [2:0]    pend_ff, pend_in;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (req_xfer && !rsp_xfer) begin
         pend_in = pend_ff + 1'b1;
      end else if (!req_xfer && rsp_xfer && (pend_ff != '0)) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ranks_low)
         && $stable(rsp_ranks_high) && $stable(rsp_all_same))
      else $error("stalled result changed");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (pend_ff != 3'd0) || req_xfer)
      else $error("result transfer without a pending request");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd2)
      else $error("more than two items in flight");

   a_same_ranks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_same |-> (rsp_ranks_low == rsp_ranks_high)
         && (rsp_ranks_low[63:8] == rsp_ranks_low[55:0]))
      else $error("all-same flag with differing ranks");

endmodule

bind interleaved_move_to_front_16lane_unit imtf_checker u_imtf_checker (.*);

// ===== test/interleaved_move_to_front_16lane_unit_tb.sv =====
// ----------------------------------------------------------------------------
// interleaved_move_to_front_16lane_unit_tb: self-checking bench of the ranker
// Sends blocks of sixteen bytes and keeps its own sixteen move-to-front lists
// to predict the rank of every lane and the all-equal flag. Directed blocks
// cover the list extremes, tail blocks and oversized lane counts; random
// traffic mostly picks bytes near the front of each list so that full blocks
// keep reshaping the lists. Both sides idle and stall at random, the output
// is held off long enough to back the block up, and the sender pauses once
// until every result is back.
// ----------------------------------------------------------------------------
module interleaved_move_to_front_16lane_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import imtf_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 300;
   localparam int DRAIN_LIMIT = 20000;
   localparam int PRINT_LIMIT = 40;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [63:0]   req_symbols_low = '0;
   logic [63:0]   req_symbols_high = '0;
   logic [4:0]    req_lane_count = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [63:0]   rsp_ranks_low;
   logic [63:0]   rsp_ranks_high;
   logic          rsp_all_same;

   logic [SYM_W-1:0] mtf_list [LANES][SYMBOLS];
   result_type       rank_queue [$];

   logic tx_gaps_on = 1'b1;
   logic rx_stalls_on = 1'b1;
   int   hold_ticket = 0;
   int   hold_served = 0;
   int   stall_left = 0;

   int error_count = 0;
   int blocks_sent = 0;
   int full_blocks = 0;
   int tail_blocks = 0;
   int results_checked = 0;
   int equal_results = 0;

   interleaved_move_to_front_16lane_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_symbols_low  (req_symbols_low),
      .req_symbols_high (req_symbols_high),
      .req_lane_count   (req_lane_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ranks_low    (rsp_ranks_low),
      .rsp_ranks_high   (rsp_ranks_high),
      .rsp_all_same     (rsp_all_same)
   );

   always #4 clock = ~clock;

   initial begin
      #8_000_000;
      $display("interleaved_move_to_front_16lane_unit_tb: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
      end
   endtask

   task automatic restore_lists();
      for (int l = 0; l < LANES; l++) begin
         for (int k = 0; k < SYMBOLS; k++) begin
            mtf_list[l][k] = SYM_W'(k);
         end
      end
   endtask

   function automatic lane_vec_type symbols_at(input lane_vec_type ranks);
      lane_vec_type syms;
      for (int i = 0; i < LANES; i++) begin
         syms[i] = mtf_list[i][ranks[i]];
      end
      return syms;
   endfunction

   function automatic lane_vec_type random_bytes();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // Computes the expected ranks of one accepted block and, for a full block,
   // moves every lane's byte to the front of that lane's list.
   task automatic rank_block(input lane_vec_type syms, input logic [4:0] lane_count);
      result_type want;
      int         pos [LANES];
      int         active;
      logic       full;
      logic [SYM_W-1:0] held;
      full = (lane_count >= LANES);
      active = full ? LANES : int'(lane_count);
      want.ranks = '0;
      want.all_same = full;
      for (int i = 0; i < active; i++) begin
         pos[i] = SYMBOLS;
         for (int r = 0; r < SYMBOLS; r++) begin
            if (pos[i] == SYMBOLS && mtf_list[i][r] == syms[i]) begin
               pos[i] = r;
            end
         end
         want.ranks[i] = (pos[i] < SYMBOLS) ? SYM_W'(pos[i]) : NOT_FOUND;
         if (i > 0 && want.ranks[i] != want.ranks[0]) begin
            want.all_same = 1'b0;
         end
      end
      if (full) begin
         full_blocks++;
         for (int i = 0; i < LANES; i++) begin
            if (pos[i] < SYMBOLS) begin
               held = mtf_list[i][pos[i]];
               for (int r = pos[i]; r > 0; r--) begin
                  mtf_list[i][r] = mtf_list[i][r-1];
               end
               mtf_list[i][0] = held;
            end
         end
      end else begin
         tail_blocks++;
      end
      rank_queue.push_back(want);
   endtask

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (!tx_gaps_on || pick < 60) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_block(input lane_vec_type syms, input logic [4:0] lane_count);
      int gap;
      req_valid        <= 1'b1;
      req_symbols_low  <= syms[7:0];
      req_symbols_high <= syms[15:8];
      req_lane_count   <= lane_count;
      do begin
         @(posedge clock);
      end while (req_stall);
      blocks_sent++;
      rank_block(syms, lane_count);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (rank_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      int pick;
      if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_stalls_on) begin
         pick = $urandom_range(0, 99);
         if (pick >= 96) begin
            stall_left = $urandom_range(20, 60);
         end else if (pick >= 70) begin
            stall_left = $urandom_range(1, 4);
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rank_queue.size() == 0) begin
            report_mismatch("unexpected transfer, ranks_low", rsp_ranks_low, '0);
         end else begin
            want = rank_queue.pop_front();
            results_checked++;
            if (want.all_same) begin
               equal_results++;
            end
            if (rsp_ranks_low !== want.ranks[7:0]) begin
               report_mismatch("ranks_low", rsp_ranks_low, want.ranks[7:0]);
            end
            if (rsp_ranks_high !== want.ranks[15:8]) begin
               report_mismatch("ranks_high", rsp_ranks_high, want.ranks[15:8]);
            end
            if (rsp_all_same !== want.all_same) begin
               report_mismatch("all_same", 64'(rsp_all_same), 64'(want.all_same));
            end
         end
      end
   end

   task automatic test_directed_cases();
      lane_vec_type syms;
      lane_vec_type ranks;
      tx_gaps_on = 1'b1;
      send_block('0, 5'd16);
      send_block('1, 5'd16);
      send_block('1, 5'd16);
      send_block(random_bytes(), 5'd0);
      send_block(random_bytes(), 5'd1);
      send_block(random_bytes(), 5'd8);
      send_block(random_bytes(), 5'd9);
      send_block(random_bytes(), 5'd15);
      ranks = {LANES{NOT_FOUND}};
      syms = symbols_at(ranks);
      send_block(syms, 5'd15);
      send_block(syms, 5'd16);
      send_block({8{16'h55AA}}, 5'd16);
      send_block({8{16'hAA55}}, 5'd16);
      ranks = {LANES{8'd7}};
      send_block(symbols_at(ranks), 5'd17);
      ranks = {LANES{8'd200}};
      send_block(symbols_at(ranks), 5'd31);
      ranks = {LANES{8'd3}};
      ranks[15] = 8'd4;
      send_block(symbols_at(ranks), 5'd16);
      ranks = {LANES{8'd2}};
      send_block(symbols_at(ranks), 5'd15);
      for (int i = 0; i < LANES; i++) begin
         syms[i] = SYM_W'(i * 17);
      end
      send_block(syms, 5'd16);
      wait_for_results();
   endtask

   task automatic test_back_to_back();
      lane_vec_type ranks;
      tx_gaps_on = 1'b0;
      rx_stalls_on <= 1'b0;
      for (int n = 0; n < 30; n++) begin
         for (int i = 0; i < LANES; i++) begin
            ranks[i] = SYM_W'($urandom_range(0, 3));
         end
         send_block(symbols_at(ranks), (n % 5 == 4) ? 5'd12 : 5'd16);
      end
      wait_for_results();
      tx_gaps_on = 1'b1;
      rx_stalls_on <= 1'b1;
   endtask

   task automatic test_random_traffic(input int count);
      lane_vec_type syms;
      lane_vec_type ranks;
      lane_vec_type last_syms;
      logic [4:0]   lane_count;
      logic [7:0]   level;
      int           pick;
      last_syms = '0;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         lane_count = 5'd16;
         for (int i = 0; i < LANES; i++) begin
            ranks[i] = SYM_W'($urandom_range(0, 7));
         end
         if (pick < 45) begin
            syms = symbols_at(ranks);
         end else if (pick < 55) begin
            level = 8'($urandom_range(0, 255));
            syms = symbols_at({LANES{level}});
            lane_count = 5'($urandom_range(16, 31));
         end else if (pick < 65) begin
            syms = last_syms;
         end else if (pick < 80) begin
            syms = random_bytes();
         end else if (pick < 95) begin
            lane_count = 5'($urandom_range(0, 15));
            syms = (pick < 88) ? random_bytes() : symbols_at(ranks);
         end else begin
            lane_count = 5'($urandom_range(17, 31));
            syms = symbols_at(ranks);
         end
         send_block(syms, lane_count);
         last_syms = syms;
      end
      wait_for_results();
   endtask

   task automatic test_output_hold();
      lane_vec_type ranks;
      tx_gaps_on = 1'b0;
      hold_ticket <= hold_ticket + 1;
      for (int n = 0; n < 10; n++) begin
         for (int i = 0; i < LANES; i++) begin
            ranks[i] = SYM_W'($urandom_range(0, 5));
         end
         send_block(symbols_at(ranks), 5'd16);
      end
      wait_for_results();
      tx_gaps_on = 1'b1;
   endtask

   task automatic test_paused_sender();
      lane_vec_type ranks;
      for (int phase = 0; phase < 2; phase++) begin
         for (int n = 0; n < 10; n++) begin
            for (int i = 0; i < LANES; i++) begin
               ranks[i] = SYM_W'($urandom_range(0, 15));
            end
            send_block(symbols_at(ranks), 5'($urandom_range(14, 18)));
         end
         wait_for_results();
      end
   endtask

   task automatic finish_run();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (rank_queue.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (rank_queue.size() != 0) begin
         report_mismatch("results never delivered", 64'(rank_queue.size()), '0);
      end
      $display("Sent %0d blocks (%0d full, %0d tail), checked %0d results.",
               blocks_sent, full_blocks, tail_blocks, results_checked);
      $display("%0d results had all sixteen ranks equal; %0d mismatches counted.",
               equal_results, error_count);
      if (error_count == 0) begin
         $display("interleaved_move_to_front_16lane_unit_tb: done, clean");
      end else begin
         $display("interleaved_move_to_front_16lane_unit_tb: done, errors");
      end
      $finish;
   endtask

   initial begin
      restore_lists();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_back_to_back();
      test_random_traffic(320);
      test_output_hold();
      test_paused_sender();
      finish_run();
   end

endmodule

// ===== filelist.f =====
rtl/core/imtf_pkg.sv
rtl/core/imtf_ram.sv
rtl/core/imtf_row_update.sv
rtl/core/imtf_engine.sv
rtl/core/interleaved_move_to_front_16lane_unit.sv
rtl/core/imtf_checker.sv
test/interleaved_move_to_front_16lane_unit_tb.sv
